// File: hw/rtl/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Shared wrappers for concurrent assertions clocked on clk_i.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked at every rising edge of clk_i while rst_ni is high.
`define ASSERT_CLK(lbl, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) \
    else $error("assertion failed");

// Checked at every rising edge of clk_i, during reset too.
`define ASSERT_ALWAYS(lbl, prop) \
  lbl: assert property (@(posedge clk_i) (prop)) \
    else $error("assertion failed");

`endif

// File: hw/rtl/lbbp_pkg.sv
// ----------------------------------------------------------------------------
// LRU block buffer pool package
// Sizes, command codes and shared types of the block buffer pool.
// ----------------------------------------------------------------------------
package lbbp_pkg;

  localparam int unsigned SLOTS        = 16;
  localparam int unsigned BLOCK_BITS   = 32;
  localparam int unsigned MAX_PREFETCH = 64;

  localparam int unsigned CNT_W   = $clog2(SLOTS + 1);
  localparam int unsigned CMD_W   = 2;
  localparam int unsigned LEN_W   = 7;
  localparam int unsigned CFG_W   = 5;
  localparam int unsigned FILL_W  = 5;
  localparam int unsigned TOTAL_W = 32;

  localparam logic [CFG_W-1:0] CAP_RESET = CFG_W'(16);

  typedef enum logic [CMD_W-1:0] {
    CMD_LOOKUP   = 2'd0,
    CMD_INSERT   = 2'd1,
    CMD_PREFETCH = 2'd2
  } cmd_e;

  typedef struct packed {
    logic                  en;
    logic [BLOCK_BITS-1:0] key;
  } cell_op_t;

  typedef struct packed {
    logic                  en;
    logic                  insert;
    logic [BLOCK_BITS-1:0] key;
    logic [CNT_W-1:0]      miss_slot;
  } ctrl_op_t;

endpackage

// File: hw/rtl/lbbp_if.sv
// ----------------------------------------------------------------------------
// LRU block buffer pool channels
// Request, response and configuration channels with valid/ready handshake.
// ----------------------------------------------------------------------------
interface lbbp_req_if import lbbp_pkg::*; ();
  logic                  valid;
  logic                  ready;
  logic [CMD_W-1:0]      command;
  logic [BLOCK_BITS-1:0] block_number;
  logic [LEN_W-1:0]      range_length;

  modport source (output valid, command, block_number, range_length, input ready);
  modport sink (input valid, command, block_number, range_length, output ready);
endinterface

interface lbbp_rsp_if import lbbp_pkg::*; ();
  logic               valid;
  logic               ready;
  logic               found;
  logic [FILL_W-1:0]  filled_count;
  logic [TOTAL_W-1:0] hit_total;
  logic [TOTAL_W-1:0] miss_total;

  modport source (output valid, found, filled_count, hit_total, miss_total, input ready);
  modport sink (input valid, found, filled_count, hit_total, miss_total, output ready);
endinterface

interface lbbp_cfg_if import lbbp_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [CFG_W-1:0] capacity_in_use;

  modport source (output valid, capacity_in_use, input ready);
  modport sink (input valid, capacity_in_use, output ready);
endinterface

// File: hw/rtl/lru_block_buffer_pool.sv
// ----------------------------------------------------------------------------
// LRU block buffer pool
// Fully associative pool of block numbers with least-recently-used
// replacement, kept as a row of cells ordered from most to least recent.
//
//   channel  direction  beat
//   req_i    in         command, block_number, range_length
//   rsp_o    out        found, filled_count, hit_total, miss_total
//   cfg_i    in         capacity_in_use
//
// On a lookup or insert all cells compare the key at once and the row
// shifts by one position up to the hit or victim cell.
// A prefetch of n blocks passes one insert through the cell row per cycle
// (none when n is zero); the next request waits until it is done.
// A result waits in an output register; a new request is taken in the cycle
// that register drains. Reset clears occupancy and counters at once and sets
// the capacity to 16.
// ----------------------------------------------------------------------------
module lru_block_buffer_pool import lbbp_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  lbbp_req_if.sink    req_i,
  lbbp_rsp_if.source  rsp_o,
  lbbp_cfg_if.sink    cfg_i
);

  ctrl_op_t              op;
  cell_op_t              cell_op;
  logic [CNT_W-1:0]      occ;
  logic [SLOTS-1:0]      match;
  logic [SLOTS:0]        take;
  logic [BLOCK_BITS-1:0] block [SLOTS];
  logic                  any_hit;

  lbbp_ctrl u_ctrl (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .req_i     (req_i),
    .rsp_o     (rsp_o),
    .cfg_i     (cfg_i),
    .any_hit_i (any_hit),
    .occ_o     (occ),
    .op_o      (op)
  );

  assign cell_op.en  = op.en;
  assign cell_op.key = op.key;
  assign any_hit     = |match;
  assign take[SLOTS] = 1'b0;

  for (genvar j = 0; j < SLOTS; j++) begin : g_cell
    logic [BLOCK_BITS-1:0] shift_in;
    logic                  boundary;

    if (j == 0) begin : g_head
      assign shift_in = op.key;
    end else begin : g_body
      assign shift_in = block[j-1];
    end

    assign boundary = op.insert && !any_hit && (op.miss_slot == CNT_W'(j));

    lbbp_cell u_cell (
      .clk_i      (clk_i),
      .op_i       (cell_op),
      .valid_i    (CNT_W'(j) < occ),
      .shift_i    (shift_in),
      .take_i     (take[j+1]),
      .boundary_i (boundary),
      .match_o    (match[j]),
      .take_o     (take[j]),
      .block_o    (block[j])
    );
  end

endmodule

// File: hw/rtl/lbbp_cell.sv
// ----------------------------------------------------------------------------
// LRU block buffer pool cell
// One recency position: holds a block, compares it with the key and takes
// the block of its more recent neighbor when the shift reaches it.
// ----------------------------------------------------------------------------
module lbbp_cell import lbbp_pkg::*; (
  input  logic                  clk_i,
  input  cell_op_t              op_i,
  input  logic                  valid_i,
  input  logic [BLOCK_BITS-1:0] shift_i,
  input  logic                  take_i,
  input  logic                  boundary_i,
  output logic                  match_o,
  output logic                  take_o,
  output logic [BLOCK_BITS-1:0] block_o
);

  logic [BLOCK_BITS-1:0] block_q;

  assign match_o = valid_i & (block_q == op_i.key);
  assign take_o  = take_i | match_o | boundary_i;
  assign block_o = block_q;

  always_ff @(posedge clk_i) begin
    if (op_i.en && take_o) begin
      block_q <= shift_i;
    end
  end

endmodule

// File: hw/rtl/lbbp_ctrl.sv
// ----------------------------------------------------------------------------
// LRU block buffer pool control
// Handshakes, capacity register, occupancy, counters and prefetch sequencing.
// ----------------------------------------------------------------------------
module lbbp_ctrl import lbbp_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  lbbp_req_if.sink          req_i,
  lbbp_rsp_if.source        rsp_o,
  lbbp_cfg_if.sink          cfg_i,
  input  logic              any_hit_i,
  output logic [CNT_W-1:0]  occ_o,
  output ctrl_op_t          op_o
);

  logic                  busy_q, busy_d;
  logic [LEN_W-1:0]      remain_q, remain_d;
  logic [BLOCK_BITS-1:0] next_q, next_d;
  logic [CNT_W-1:0]      occ_q, occ_d;
  logic [TOTAL_W-1:0]    hit_q, hit_d;
  logic [TOTAL_W-1:0]    miss_q, miss_d;
  logic [CFG_W-1:0]      cap_q;
  logic                  rsp_valid_q, rsp_valid_d;
  logic                  found_q, found_d;
  logic [FILL_W-1:0]     filled_q;
  logic [TOTAL_W-1:0]    hit_out_q, miss_out_q;

  logic [CNT_W-1:0] eff_cap;
  logic             full;
  logic             req_fire;
  logic [LEN_W-1:0] len_c;
  logic             is_lookup, is_insert, is_prefetch, long_prefetch;
  logic             rsp_load;
  logic             add_new;

  assign cfg_i.ready = 1'b1;

  always_comb begin
    if (cap_q == '0) begin
      eff_cap = CNT_W'(1);
    end else if (32'(cap_q) > SLOTS) begin
      eff_cap = CNT_W'(SLOTS);
    end else begin
      eff_cap = CNT_W'(cap_q);
    end
  end

  assign full        = occ_q >= eff_cap;
  assign req_i.ready = !busy_q && (!rsp_valid_q || rsp_o.ready);
  assign req_fire    = req_i.valid && req_i.ready;

  assign is_lookup   = req_i.command == CMD_LOOKUP;
  assign is_insert   = req_i.command == CMD_INSERT;
  assign is_prefetch = req_i.command == CMD_PREFETCH;
  assign len_c       = (32'(req_i.range_length) > MAX_PREFETCH) ? LEN_W'(MAX_PREFETCH)
                                                                 : req_i.range_length;
  assign long_prefetch = is_prefetch && (len_c > LEN_W'(1));

  always_comb begin
    op_o.en        = 1'b0;
    op_o.insert    = 1'b0;
    op_o.key       = req_i.block_number;
    op_o.miss_slot = full ? occ_q - CNT_W'(1) : occ_q;
    if (busy_q) begin
      op_o.en     = 1'b1;
      op_o.insert = 1'b1;
      op_o.key    = next_q;
    end else if (req_fire) begin
      case (req_i.command)
        CMD_LOOKUP: begin
          op_o.en = 1'b1;
        end
        CMD_INSERT: begin
          op_o.en     = 1'b1;
          op_o.insert = 1'b1;
        end
        CMD_PREFETCH: begin
          op_o.en     = len_c != '0;
          op_o.insert = 1'b1;
        end
        default: begin
          op_o.en = 1'b0;
        end
      endcase
    end
  end

  assign add_new = op_o.en && op_o.insert && !any_hit_i && !full;
  assign occ_d   = occ_q + CNT_W'(add_new);
  assign occ_o   = occ_q;

  always_comb begin
    hit_d  = hit_q;
    miss_d = miss_q;
    if (req_fire && is_lookup) begin
      if (any_hit_i) begin
        if (hit_q != '1) begin
          hit_d = hit_q + TOTAL_W'(1);
        end
      end else if (miss_q != '1) begin
        miss_d = miss_q + TOTAL_W'(1);
      end
    end
  end

  always_comb begin
    busy_d   = busy_q;
    remain_d = remain_q;
    next_d   = next_q;
    rsp_load = 1'b0;
    found_d  = 1'b0;
    if (busy_q) begin
      next_d   = next_q + BLOCK_BITS'(1);
      remain_d = remain_q - LEN_W'(1);
      if (remain_q == LEN_W'(1)) begin
        busy_d   = 1'b0;
        rsp_load = 1'b1;
      end
    end else if (req_fire) begin
      if (long_prefetch) begin
        busy_d   = 1'b1;
        remain_d = len_c - LEN_W'(1);
        next_d   = req_i.block_number + BLOCK_BITS'(1);
      end else begin
        rsp_load = 1'b1;
        found_d  = (is_lookup || is_insert) && any_hit_i;
      end
    end
  end

  always_comb begin
    if (rsp_load) begin
      rsp_valid_d = 1'b1;
    end else if (rsp_o.ready) begin
      rsp_valid_d = 1'b0;
    end else begin
      rsp_valid_d = rsp_valid_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q      <= 1'b0;
      remain_q    <= '0;
      next_q      <= '0;
      occ_q       <= '0;
      hit_q       <= '0;
      miss_q      <= '0;
      cap_q       <= CAP_RESET;
      rsp_valid_q <= 1'b0;
    end else begin
      busy_q      <= busy_d;
      remain_q    <= remain_d;
      next_q      <= next_d;
      occ_q       <= occ_d;
      hit_q       <= hit_d;
      miss_q      <= miss_d;
      rsp_valid_q <= rsp_valid_d;
      if (cfg_i.valid && cfg_i.ready) begin
        cap_q <= cfg_i.capacity_in_use;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (rsp_load) begin
      found_q    <= found_d;
      filled_q   <= FILL_W'(occ_d);
      hit_out_q  <= hit_d;
      miss_out_q <= miss_d;
    end
  end

  assign rsp_o.valid        = rsp_valid_q;
  assign rsp_o.found        = found_q;
  assign rsp_o.filled_count = filled_q;
  assign rsp_o.hit_total    = hit_out_q;
  assign rsp_o.miss_total   = miss_out_q;

endmodule

// File: hw/rtl/lbbp_checker.sv
// ----------------------------------------------------------------------------
// LRU block buffer pool checker
// Port-level checks on the response channel, bound to the top level.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module lbbp_checker import lbbp_pkg::*; (
  input logic               clk_i,
  input logic               rst_ni,
  input logic               rsp_valid_i,
  input logic               rsp_ready_i,
  input logic [FILL_W-1:0]  filled_count_i,
  input logic [TOTAL_W-1:0] hit_total_i,
  input logic [TOTAL_W-1:0] miss_total_i
);

  logic rsp_fire;

  assign rsp_fire = rsp_valid_i && rsp_ready_i;

  `ASSERT_CLK(a_fill_bound, rsp_valid_i |-> 32'(filled_count_i) <= SLOTS)
  `ASSERT_CLK(a_hit_monotonic, rsp_fire |=> !rsp_valid_i || hit_total_i >= $past(hit_total_i))
  `ASSERT_CLK(a_miss_monotonic, rsp_fire |=> !rsp_valid_i || miss_total_i >= $past(miss_total_i))
  `ASSERT_CLK(a_fill_monotonic,
              rsp_fire |=> !rsp_valid_i || filled_count_i >= $past(filled_count_i))
  `ASSERT_CLK(a_rsp_hold,
              rsp_valid_i && !rsp_ready_i |=> rsp_valid_i && $stable(hit_total_i))

endmodule

bind lru_block_buffer_pool lbbp_checker u_lbbp_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .rsp_valid_i    (rsp_o.valid),
  .rsp_ready_i    (rsp_o.ready),
  .filled_count_i (rsp_o.filled_count),
  .hit_total_i    (rsp_o.hit_total),
  .miss_total_i   (rsp_o.miss_total)
);
